### hdl/ivl2n_pkg.sv
// Shared constants, types and state codes for the int8 vector L2 norm block.
package ivl2n_pkg;

  localparam int LANES             = 8;
  localparam int SAMPLE_W          = 8;
  localparam int LANE_CNT_W        = 4;
  localparam int SQ_W              = 2 * SAMPLE_W - 1;
  localparam int ADD_W             = SQ_W + $clog2(LANES + 1);
  localparam int MAX_ELEMENTS_LOG2 = 24;
  localparam int CNT_W             = MAX_ELEMENTS_LOG2 + 1;
  localparam int SUM_W             = 39;
  localparam int FRACTION_BITS     = 8;
  localparam int NORM_W            = 28;
  localparam int RAD_W             = 2 * NORM_W;
  localparam int REM_W             = NORM_W + 3;
  localparam int STEP_W            = $clog2(NORM_W);

  localparam logic [CNT_W-1:0] MAX_ELEMENTS = {1'b1, {MAX_ELEMENTS_LOG2{1'b0}}};
  localparam logic [SUM_W-1:0] SUM_BOUND    =
      SUM_W'(MAX_ELEMENTS) << (2 * (SAMPLE_W - 1));
  localparam logic [LANE_CNT_W-1:0] LANE_LIMIT = LANE_CNT_W'(LANES);

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_DONE
  } sq_state_e;

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [LANE_CNT_W-1:0] lanes;
  } chunk_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } acc_res_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [NORM_W-1:0] norm;
    logic              ovf;
  } norm_res_t;

endpackage

### hdl/ivl2n_if.sv
// Valid/ready channel interfaces for vector chunks and norm results.
interface ivl2n_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample_0;
  logic signed [7:0] sample_1;
  logic signed [7:0] sample_2;
  logic signed [7:0] sample_3;
  logic signed [7:0] sample_4;
  logic signed [7:0] sample_5;
  logic signed [7:0] sample_6;
  logic signed [7:0] sample_7;
  logic [3:0]        lane_count;
  logic              last;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7, lane_count, last,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7, lane_count, last,
    output ready
  );
endinterface

interface ivl2n_out_if;
  logic        valid;
  logic        ready;
  logic [38:0] sum_of_squares;
  logic [27:0] norm_fixed;
  logic        overflow;

  modport source (
    output valid, sum_of_squares, norm_fixed, overflow,
    input  ready
  );
  modport sink (
    input  valid, sum_of_squares, norm_fixed, overflow,
    output ready
  );
endinterface

### hdl/int8_vector_l2_norm.sv
// Int8 vector L2 norm: eight squaring lanes, a merge/accumulate stage, a serial root.
// Throughput: one chunk per cycle while a vector streams in (lane_count up to eight).
// After the last chunk, the result is formed by the 28-step serial root unit;
// input ready stays low from the last chunk until the result is registered.
// The next vector's chunks are taken while that result waits in the output register.
// Reset: asynchronous, active low; clears the sum, count, overflow flag and all valids.
module int8_vector_l2_norm
  import ivl2n_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ivl2n_in_if.sink    in_i,
  ivl2n_out_if.source out_o
);

  logic [LANES-1:0][SAMPLE_W-1:0] samples;
  logic [LANES-1:0][SQ_W-1:0]     sq;
  logic [LANE_CNT_W-1:0]          lanes_clamped;
  logic                           accept;
  chunk_ctl_t                     ctl_q;
  acc_res_t                       acc;
  norm_res_t                      root_res, out_q;
  logic                           root_done, take;
  logic                           busy_q, out_valid_q;

  assign samples = {in_i.sample_7, in_i.sample_6, in_i.sample_5, in_i.sample_4,
                    in_i.sample_3, in_i.sample_2, in_i.sample_1, in_i.sample_0};

  assign in_i.ready    = !busy_q;
  assign accept        = in_i.valid && !busy_q;
  assign lanes_clamped = (in_i.lane_count > LANE_LIMIT) ? LANE_LIMIT : in_i.lane_count;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    ivl2n_lane u_lane (
      .clk_i    (clk_i),
      .sample_i (samples[k]),
      .en_i     (lanes_clamped > LANE_CNT_W'(k)),
      .sq_o     (sq[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= accept;
      ctl_q.last  <= in_i.last;
      ctl_q.lanes <= lanes_clamped;
    end
  end

  ivl2n_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_q),
    .sq_i   (sq),
    .res_o  (acc)
  );

  ivl2n_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .take_i (take),
    .done_o (root_done),
    .res_o  (root_res)
  );

  // move the finished root into the output register when it is free
  assign take = root_done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && in_i.last) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= root_res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sum_of_squares = out_q.sum;
  assign out_o.norm_fixed     = out_q.norm;
  assign out_o.overflow       = out_q.ovf;

endmodule

### hdl/ivl2n_lane.sv
// One lane: squares a signed sample when the lane is enabled, registered.
module ivl2n_lane
  import ivl2n_pkg::*;
(
  input  logic                       clk_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       en_i,
  output logic [SQ_W-1:0]            sq_o
);

  logic signed [2*SAMPLE_W-1:0] prod;
  logic [SQ_W-1:0]              sq_d, sq_q;

  assign prod = sample_i * sample_i;
  assign sq_d = en_i ? prod[SQ_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

### hdl/ivl2n_merge.sv
// Merge stage: sums the lane squares and accumulates with saturation.
module ivl2n_merge
  import ivl2n_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  chunk_ctl_t                 ctl_i,
  input  logic [LANES-1:0][SQ_W-1:0] sq_i,
  output acc_res_t                   res_o
);

  logic [ADD_W-1:0] add_d, add_q;
  chunk_ctl_t       ctl_q;
  logic [SUM_W-1:0] sum_d, sum_q, acc;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [CNT_W:0]   cnt_sum;
  logic             ovf_d, ovf_q;
  acc_res_t         res_d, res_q;

  always_comb begin
    add_d = '0;
    for (int k = 0; k < LANES; k++) begin
      add_d = add_d + ADD_W'(sq_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    add_q <= add_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_comb begin
    cnt_sum = {1'b0, cnt_q} + (CNT_W + 1)'(ctl_q.lanes);
    acc     = sum_q + SUM_W'(add_q);
    ovf_d   = ovf_q;
    if (cnt_sum > {1'b0, MAX_ELEMENTS}) begin
      // too many elements: pin to the bound and stay there
      ovf_d = 1'b1;
      sum_d = SUM_BOUND;
      cnt_d = MAX_ELEMENTS;
    end else begin
      cnt_d = cnt_sum[CNT_W-1:0];
      if (ovf_q || acc > SUM_BOUND) begin
        sum_d = SUM_BOUND;
      end else begin
        sum_d = acc;
      end
    end
    res_d.valid = ctl_q.valid && ctl_q.last;
    res_d.sum   = sum_d;
    res_d.ovf   = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      res_q <= '0;
    end else begin
      res_q.valid <= res_d.valid;
      if (res_d.valid) begin
        res_q.sum <= res_d.sum;
        res_q.ovf <= res_d.ovf;
      end
      if (ctl_q.valid) begin
        if (ctl_q.last) begin
          sum_q <= '0;
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
          ovf_q <= ovf_d;
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

### hdl/ivl2n_sqrt.sv
// Iterative digit-by-digit square root, one root bit per cycle.
module ivl2n_sqrt
  import ivl2n_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  acc_res_t  acc_i,
  input  logic      take_i,
  output logic      done_o,
  output norm_res_t res_o
);

  sq_state_e          state_q, state_d;
  logic               load, iter;
  logic [RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]   rem_q, rem_sh, trial, rem_d;
  logic [NORM_W-1:0]  root_q;
  logic [STEP_W-1:0]  step_q;
  logic [SUM_W-1:0]   sum_q;
  logic               ovf_q;
  logic               ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    iter    = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      SQ_IDLE: begin
        if (acc_i.valid) begin
          load    = 1'b1;
          state_d = SQ_RUN;
        end
      end
      SQ_RUN: begin
        iter = 1'b1;
        if (step_q == STEP_W'(NORM_W - 1)) begin
          state_d = SQ_DONE;
        end
      end
      SQ_DONE: begin
        done_o = 1'b1;
        if (take_i) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rem_d  = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk_i) begin
    if (load) begin
      rad_q  <= RAD_W'(acc_i.sum) << (2 * FRACTION_BITS);
      rem_q  <= '0;
      root_q <= '0;
      step_q <= '0;
      sum_q  <= acc_i.sum;
      ovf_q  <= acc_i.ovf;
    end else if (iter) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= {root_q[NORM_W-2:0], ge};
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign res_o.sum  = sum_q;
  assign res_o.norm = root_q;
  assign res_o.ovf  = ovf_q;

endmodule

### sim/ivl2n_norm_check_pkg.sv
// Chunk type and the running-norm tracker that predicts and checks L2 norm results.
`timescale 1ns / 100ps
package ivl2n_norm_check_pkg;
  import ivl2n_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp [8];
    logic [LANE_CNT_W-1:0]      lanes;
    logic                       last;
  } chunk_t;

  class norm_tracker;
    logic [SUM_W-1:0] run_sum;
    logic [CNT_W-1:0] elem_count;
    logic             ovf_seen;
    norm_res_t        pending_norms [$];
    int               mismatches;

    function new();
      clear_vector();
      mismatches = 0;
    endfunction

    function void clear_vector();
      run_sum    = '0;
      elem_count = '0;
      ovf_seen   = 1'b0;
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // floor(sqrt(s) * 2^FRACTION_BITS), built one root bit at a time
    function logic [NORM_W-1:0] fixed_sqrt(logic [SUM_W-1:0] s);
      logic [63:0] rad;
      logic [63:0] root;
      logic [63:0] trial;
      rad  = 64'(s) << (2 * FRACTION_BITS);
      root = '0;
      for (int b = NORM_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= rad) root = trial;
      end
      return root[NORM_W-1:0];
    endfunction

    function void take_chunk(chunk_t c);
      logic [LANE_CNT_W-1:0] n;
      logic [CNT_W:0]        cnt_next;
      logic [SUM_W:0]        wide;
      norm_res_t             res;
      int                    add;
      int                    sv;
      n        = (c.lanes > LANE_LIMIT) ? LANE_LIMIT : c.lanes;
      cnt_next = {1'b0, elem_count} + (CNT_W + 1)'(n);
      if (cnt_next > (CNT_W + 1)'(MAX_ELEMENTS)) begin
        // too many elements: pin the sum at the bound and stick the flag
        ovf_seen   = 1'b1;
        run_sum    = SUM_BOUND;
        elem_count = MAX_ELEMENTS;
      end else begin
        add = 0;
        for (int k = 0; k < 8; k++) begin
          if (k < int'(n)) begin
            sv  = int'(c.smp[k]);
            add += sv * sv;
          end
        end
        elem_count = cnt_next[CNT_W-1:0];
        if (ovf_seen) begin
          run_sum = SUM_BOUND;
        end else begin
          wide    = {1'b0, run_sum} + (SUM_W + 1)'(add);
          run_sum = (wide > {1'b0, SUM_BOUND}) ? SUM_BOUND : wide[SUM_W-1:0];
        end
      end
      if (c.last) begin
        res.sum  = run_sum;
        res.norm = fixed_sqrt(run_sum);
        res.ovf  = ovf_seen;
        pending_norms = {pending_norms, res};
        clear_vector();
      end
    endfunction

    task check_result(norm_res_t got);
      norm_res_t want;
      if (pending_norms.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sum=%0d norm=%0d ovf=%0b",
                                got.sum, got.norm, got.ovf));
      end else begin
        want = pending_norms.pop_front();
        if (got.sum !== want.sum)
          flag_mismatch($sformatf("sum_of_squares %0d, want %0d", got.sum, want.sum));
        if (got.norm !== want.norm)
          flag_mismatch($sformatf("norm_fixed %0d, want %0d", got.norm, want.norm));
        if (got.ovf !== want.ovf)
          flag_mismatch($sformatf("overflow %0b, want %0b", got.ovf, want.ovf));
      end
    endtask

    function int waiting();
      return pending_norms.size();
    endfunction
  endclass

endpackage

### sim/int8_vector_l2_norm_test.sv
// Testbench top for the int8 vector L2 norm block: chunk driver, result sink, checks.
`timescale 1ns / 100ps
module int8_vector_l2_norm_test;
  import ivl2n_pkg::*;
  import ivl2n_norm_check_pkg::*;

  localparam int CYCLE_LIMIT = 300_000;

  logic clk_i;
  logic rst_ni;
  bit   no_gaps;
  int   cycle_count;

  ivl2n_in_if  in_if ();
  ivl2n_out_if out_if ();

  norm_tracker tracker = new();

  int8_vector_l2_norm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic chunk_t lane_fill(int val, int lanes, bit last);
    chunk_t c;
    for (int k = 0; k < 8; k++) c.smp[k] = SAMPLE_W'(val);
    c.lanes = LANE_CNT_W'(lanes);
    c.last  = last;
    return c;
  endfunction

  function automatic chunk_t rand_chunk(bit last);
    chunk_t c;
    int     pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) c.lanes = '0;
    else if (pick == 1) c.lanes = LANE_CNT_W'($urandom_range(9, 15));
    else c.lanes = LANE_CNT_W'($urandom_range(1, 8));
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 11))
        0:       c.smp[k] = -8'sd128;
        1:       c.smp[k] = 8'sd127;
        2:       c.smp[k] = '0;
        3:       c.smp[k] = -8'sd1;
        default: c.smp[k] = SAMPLE_W'($urandom_range(0, 255));
      endcase
    end
    c.last = last;
    return c;
  endfunction

  task automatic send_chunk(chunk_t c);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.sample_0   <= c.smp[0];
    in_if.sample_1   <= c.smp[1];
    in_if.sample_2   <= c.smp[2];
    in_if.sample_3   <= c.smp[3];
    in_if.sample_4   <= c.smp[4];
    in_if.sample_5   <= c.smp[5];
    in_if.sample_6   <= c.smp[6];
    in_if.sample_7   <= c.smp[7];
    in_if.lane_count <= c.lanes;
    in_if.last       <= c.last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.take_chunk(c);
  endtask

  // Send one vector of random chunks, return the item count.
  task automatic send_rand_vector(output int n);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    for (int i = 0; i < n; i++) send_chunk(rand_chunk(i == n - 1));
  endtask

  // result sink: ready in random bursts, always high once gaps are off
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_if.ready <= 1'b1;
      if (no_gaps) begin
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin
    norm_res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.sum  = out_if.sum_of_squares;
        got.norm = out_if.norm_fixed;
        got.ovf  = out_if.overflow;
        tracker.check_result(got);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    chunk_t c;
    int     sent;
    int     n;
    no_gaps          = 1'b0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.sample_0   <= '0;
    in_if.sample_1   <= '0;
    in_if.sample_2   <= '0;
    in_if.sample_3   <= '0;
    in_if.sample_4   <= '0;
    in_if.sample_5   <= '0;
    in_if.sample_6   <= '0;
    in_if.sample_7   <= '0;
    in_if.lane_count <= '0;
    in_if.last       <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty vector, extremes, clamped and zero lane counts
    send_chunk(lane_fill(0, 0, 1));
    send_chunk(lane_fill(-128, 1, 1));
    send_chunk(lane_fill(127, 8, 1));
    send_chunk(lane_fill(-128, 8, 1));
    send_chunk(lane_fill(-128, 15, 1));
    send_chunk(lane_fill(-1, 9, 0));
    c = lane_fill(-128, 3, 1);
    c.smp[3] = 8'sd127;
    c.smp[7] = -8'sd1;
    send_chunk(c);
    send_chunk(lane_fill(0, 0, 0));
    send_chunk(lane_fill(0, 0, 0));
    send_chunk(lane_fill(1, 0, 1));
    c = lane_fill(0, 8, 0);
    for (int k = 0; k < 8; k++) c.smp[k] = (k % 2) ? -8'sd128 : 8'sd127;
    send_chunk(c);
    send_chunk(lane_fill(0, 1, 0));
    send_chunk(lane_fill(-77, 5, 0));
    send_chunk(lane_fill(42, 12, 1));
    send_chunk(lane_fill(1, 1, 1));
    send_chunk(lane_fill(-2, 2, 1));
    sent = 16;

    // random vectors with gaps on both sides, then a run without gaps
    while (sent < 900) begin
      send_rand_vector(n);
      sent += n;
    end
    no_gaps = 1'b1;
    while (sent < 1100) begin
      send_rand_vector(n);
      sent += n;
    end

    // close with a full-range vector
    send_chunk(lane_fill(-128, 8, 0));
    send_chunk(lane_fill(100, 4, 1));
    in_if.valid <= 1'b0;

    while (tracker.waiting() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ivl2n_pkg.sv
hdl/ivl2n_if.sv
hdl/ivl2n_lane.sv
hdl/ivl2n_merge.sv
hdl/ivl2n_sqrt.sv
hdl/int8_vector_l2_norm.sv
sim/ivl2n_norm_check_pkg.sv
sim/int8_vector_l2_norm_test.sv
